// ===== rtl/core/cfs_pkg.sv =====
// Shared definitions for the cylinder fit residual accumulator.
// Holds the configuration bundle, register index codes and fixed field widths.
// No dependencies.
`default_nettype none

package cfs_pkg;

   // Fixed field widths.
   localparam int SLOPE_W      = 20;
   localparam int ORIGIN_W     = 24;
   localparam int RADIUS_W     = 24;
   localparam int SUM_W        = 40;
   localparam int DEN_W        = 41;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 24;
   localparam int DEF_COORD_BITS = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOPE_X  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOPE_Y  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS   = 3'd4;

   // Cylinder geometry as held in the configuration registers.
   typedef struct packed {
      logic signed [SLOPE_W-1:0]  slope_x;
      logic signed [SLOPE_W-1:0]  slope_y;
      logic signed [ORIGIN_W-1:0] origin_x;
      logic signed [ORIGIN_W-1:0] origin_y;
      logic        [RADIUS_W-1:0] radius;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/cylinder_fit_residual_sum.sv =====
// Top level of the cylinder fit residual accumulator: configuration registers,
// front end, queue and back end. Uses cfs_pkg, cfs_front, cfs_queue, cfs_back.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | point_x, point_y, point_z, last_point
//   rsp     | out       | rsp_valid/stall   | residual_total, saturated
//   csr     | in        | csr_valid/ready   | csr_index, csr_data
//
// With CW = COORD_BITS+30 (COORD_BITS counted as at least 16), each point passes
// in turn through set-up, serial squaring, division, square root, difference and
// accumulation in the shared back-end sequencer. The front end and a two-entry
// queue take up to three further points while the back end works. Reset is
// synchronous and clears the registers, the sum and all valid state; a stalled
// result holds.
`default_nettype none

module cylinder_fit_residual_sum import cfs_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire [CSR_INDEX_W-1:0]       csr_index,
   input  wire [CSR_DATA_W-1:0]        csr_data,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire signed [COORD_BITS-1:0] req_point_x,
   input  wire signed [COORD_BITS-1:0] req_point_y,
   input  wire signed [COORD_BITS-1:0] req_point_z,
   input  wire                         req_last_point,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [SUM_W-1:0]            rsp_residual_total,
   output logic                        rsp_saturated
);

   localparam int CW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 30;
   localparam int EW = 3 * CW + 1;

   cfg_type       cfg_ff, cfg_in;
   logic          q_full, q_push, q_pop, q_valid;
   logic [EW-1:0] push_entry, pop_entry;

   // Configuration registers; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SLOPE_X:  cfg_in.slope_x  = csr_data[SLOPE_W-1:0];
            CSR_SLOPE_Y:  cfg_in.slope_y  = csr_data[SLOPE_W-1:0];
            CSR_ORIGIN_X: cfg_in.origin_x = csr_data[ORIGIN_W-1:0];
            CSR_ORIGIN_Y: cfg_in.origin_y = csr_data[ORIGIN_W-1:0];
            CSR_RADIUS:   cfg_in.radius   = csr_data[RADIUS_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: request intake and cross product.
   cfs_front #(.COORD_BITS(COORD_BITS), .CW(CW)) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_last_point (req_last_point),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   // Decoupling queue.
   cfs_queue #(.EW(EW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .pop_data  (pop_entry)
   );

   // Back end: distance, residual and sum.
   cfs_back #(.COORD_BITS(COORD_BITS), .CW(CW)) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_valid            (q_valid),
      .q_entry            (pop_entry),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_residual_total (rsp_residual_total),
      .rsp_saturated      (rsp_saturated)
   );

   // A saturated total always reads as the full-scale value.
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_residual_total == {SUM_W{1'b1}})
      else $error("saturated result without full-scale total");

   // The intake only stalls when the queue is full.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_full)
      else $error("request stalled while the queue had room");

   // Nothing is popped from the queue while it is empty.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from an empty queue");

   // No result straight after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== rtl/core/cfs_front.sv =====
// Front end: accepts a point request, offsets it to the axis origin and forms
// the magnitudes of the cross product with the axis direction. Uses cfs_pkg.
`default_nettype none

module cfs_front import cfs_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int CW         = ((COORD_BITS > 16) ? COORD_BITS : 16) + 30
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire cfg_type                 cfg,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire signed [COORD_BITS-1:0]  req_point_x,
   input  wire signed [COORD_BITS-1:0]  req_point_y,
   input  wire signed [COORD_BITS-1:0]  req_point_z,
   input  wire                          req_last_point,
   input  wire                          q_full,
   output logic                         q_push,
   output logic [3*CW:0]                q_entry
);

   localparam int DW  = CW - 21;
   localparam int DZW = COORD_BITS + 8;
   localparam int PZW = DZW + SLOPE_W;
   localparam int PXW = DW + SLOPE_W;

   logic                  valid_ff, valid_in;
   logic signed [DW-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [DZW-1:0] dz_ff, dz_in;
   logic                  last_ff, last_in;
   logic                  accept;

   logic signed [PZW-1:0] pzx, pzy;
   logic signed [PXW-1:0] pxy, pyx;
   logic signed [CW-1:0]  c1, c2, c3, dxw, dyw;
   logic [CW-1:0]         m1, m2, m3;

   // The stage stalls only while it holds a request that the queue cannot take.
   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = valid_ff && !q_full;

   // Offset the point to the axis origin, in Q.8.
   always_comb begin
      valid_in = valid_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dz_in    = dz_ff;
      last_in  = last_ff;
      if (accept) begin
         valid_in = 1'b1;
         dx_in    = (DW'(req_point_x) <<< 8) - DW'(cfg.origin_x);
         dy_in    = (DW'(req_point_y) <<< 8) - DW'(cfg.origin_y);
         dz_in    = DZW'(req_point_z) <<< 8;
         last_in  = req_last_point;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      last_ff <= last_in;
   end

   // Cross product of the offset with (sx, sy, 1.0), then magnitudes.
   always_comb begin
      dxw = CW'(dx_ff);
      dyw = CW'(dy_ff);
      pzx = dz_ff * $signed(cfg.slope_x);
      pzy = dz_ff * $signed(cfg.slope_y);
      pxy = dx_ff * $signed(cfg.slope_y);
      pyx = dy_ff * $signed(cfg.slope_x);
      c1  = (dyw <<< 16) - CW'(pzy);
      c2  = CW'(pzx) - (dxw <<< 16);
      c3  = CW'(pxy) - CW'(pyx);
      m1  = c1[CW-1] ? CW'(-c1) : CW'(c1);
      m2  = c2[CW-1] ? CW'(-c2) : CW'(c2);
      m3  = c3[CW-1] ? CW'(-c3) : CW'(c3);
      q_entry = {last_ff, m3, m2, m1};
   end

endmodule

`default_nettype wire

// ===== rtl/core/cfs_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end.
// Generic over entry width; no package dependencies.
`default_nettype none

module cfs_queue #(
   parameter int EW = 1
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           push,
   input  wire [EW-1:0]  push_data,
   output logic          full,
   input  wire           pop,
   output logic          q_valid,
   output logic [EW-1:0] pop_data
);

   logic [EW-1:0] mem_ff [2];
   logic          wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]    count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign q_valid  = count_ff != 2'd0;
   assign pop_data = mem_ff[rd_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop  ? !rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cfs_back.sv =====
// Back end: serial squaring, restoring division, digit-by-digit square root,
// then the saturating residual sum and the result register. Uses cfs_pkg.
`default_nettype none

module cfs_back import cfs_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int CW         = ((COORD_BITS > 16) ? COORD_BITS : 16) + 30
) (
   input  wire               clock,
   input  wire               reset,
   input  wire cfg_type      cfg,
   input  wire               q_valid,
   input  wire [3*CW:0]      q_entry,
   output logic              q_pop,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [SUM_W-1:0]  rsp_residual_total,
   output logic              rsp_saturated
);

   localparam int NUMW = 2 * CW + 2;
   localparam int QW   = NUMW - 32;
   localparam int RW   = (QW + 1) / 2;
   localparam int VW   = 2 * RW;
   localparam int DFW  = (RW > RADIUS_W) ? RW : RADIUS_W;
   localparam int AW   = ((DFW > SUM_W) ? DFW : SUM_W) + 1;
   localparam int CNTW = $clog2(NUMW + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_DIFF   = 3'd4;
   localparam logic [2:0] ST_ACCUM  = 3'd5;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   logic [2:0]       state_ff, state_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic [1:0]       sel_ff, sel_in;
   logic [3*CW-1:0]  cs_ff, cs_in;
   logic             last_ff, last_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUMW-1:0]  num_ff, num_in, mcand_ff, mcand_in;
   logic [CW-1:0]    mplier_ff, mplier_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [VW-1:0]    op_ff, op_in, res_ff, res_in, one_ff, one_in;
   logic [DFW-1:0]   diff_ff, diff_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             ovf_ff, ovf_in;
   logic             out_valid_ff, out_valid_in;
   logic [SUM_W-1:0] out_total_ff, out_total_in;
   logic             out_sat_ff, out_sat_in;

   logic signed [2*SLOPE_W-1:0] sq_x, sq_y;
   logic [DEN_W:0]   trial;
   logic [VW-1:0]    root_sum;
   logic [DFW-1:0]   dist_q8, rad;
   logic [AW-1:0]    new_sum;
   logic             out_free;
   logic [CW-1:0]    c_next;

   assign rsp_valid          = out_valid_ff;
   assign rsp_residual_total = out_total_ff;
   assign rsp_saturated      = out_sat_ff;
   assign out_free           = !out_valid_ff || !rsp_stall;
   assign q_pop              = (state_ff == ST_IDLE) && q_valid;

   // Combinational helpers for each phase.
   always_comb begin
      sq_x     = cfg.slope_x * cfg.slope_x;
      sq_y     = cfg.slope_y * cfg.slope_y;
      trial    = {rem_ff, num_ff[NUMW-1]};
      root_sum = res_ff + one_ff;
      dist_q8  = DFW'(res_ff[RW-1:0]);
      rad      = DFW'(cfg.radius);
      new_sum  = AW'(sum_ff) + AW'(diff_ff);
      case (sel_ff)
         2'd0:    c_next = cs_ff[2*CW-1:CW];
         default: c_next = cs_ff[3*CW-1:2*CW];
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      cs_in        = cs_ff;
      last_in      = last_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      rem_in       = rem_ff;
      op_in        = op_ff;
      res_in       = res_ff;
      one_in       = one_ff;
      diff_in      = diff_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_total_in = out_total_ff;
      out_sat_in   = out_sat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cs_in     = q_entry[3*CW-1:0];
               last_in   = q_entry[3*CW];
               den_in    = DEN_W'($unsigned(sq_x)) + DEN_W'($unsigned(sq_y))
                           + (DEN_W'(1) << 32);
               num_in    = '0;
               mcand_in  = NUMW'(q_entry[CW-1:0]);
               mplier_in = q_entry[CW-1:0];
               sel_in    = 2'd0;
               cnt_in    = '0;
               state_in  = ST_SQUARE;
            end
         end
         // Shift-and-add square of each cross product component, summed.
         ST_SQUARE: begin
            if (mplier_ff[0]) begin
               num_in = num_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(CW - 1)) begin
               cnt_in = '0;
               if (sel_ff == 2'd2) begin
                  rem_in   = '0;
                  state_in = ST_DIVIDE;
               end else begin
                  sel_in    = sel_ff + 1'b1;
                  mcand_in  = NUMW'(c_next);
                  mplier_in = c_next;
               end
            end
         end
         // Restoring division, one quotient bit per cycle, in place.
         ST_DIVIDE: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = DEN_W'(trial - {1'b0, den_ff});
               num_in = {num_ff[NUMW-2:0], 1'b1};
            end else begin
               rem_in = trial[DEN_W-1:0];
               num_in = {num_ff[NUMW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(NUMW - 1)) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         // Digit-by-digit square root, one result bit per cycle.
         ST_ROOT: begin
            if (cnt_ff == '0) begin
               op_in  = num_ff[VW-1:0];
               res_in = '0;
               one_in = VW'(1) << (VW - 2);
               cnt_in = cnt_ff + 1'b1;
            end else begin
               if (op_ff >= root_sum) begin
                  op_in  = op_ff - root_sum;
                  res_in = (res_ff >> 1) + one_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               one_in = one_ff >> 2;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNTW'(RW)) begin
                  cnt_in   = '0;
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            diff_in  = (dist_q8 >= rad) ? dist_q8 - rad : rad - dist_q8;
            state_in = ST_ACCUM;
         end
         // Saturating accumulate; a last point also needs the result register.
         ST_ACCUM: begin
            if (!last_ff || out_free) begin
               if (ovf_ff || new_sum > AW'(SUM_MAX)) begin
                  sum_in = SUM_MAX;
                  ovf_in = 1'b1;
               end else begin
                  sum_in = new_sum[SUM_W-1:0];
               end
               if (last_ff) begin
                  out_valid_in = 1'b1;
                  out_total_in = sum_in;
                  out_sat_in   = ovf_in;
                  sum_in       = '0;
                  ovf_in       = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
      sel_ff       <= sel_in;
      cs_ff        <= cs_in;
      last_ff      <= last_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      rem_ff       <= rem_in;
      op_ff        <= op_in;
      res_ff       <= res_in;
      one_ff       <= one_in;
      diff_ff      <= diff_in;
      out_total_ff <= out_total_in;
      out_sat_ff   <= out_sat_in;
   end

endmodule

`default_nettype wire

// ===== sim/tb_cylinder_fit_residual_sum.sv =====
// Self-checking testbench for the cylinder fit residual accumulator.
// Streams points, predicts each set total in the bench and compares it with
// every response. Depends on cfs_pkg and cylinder_fit_residual_sum.
`timescale 1ns / 1ps

module tb_cylinder_fit_residual_sum;
   import cfs_pkg::*;

   localparam int CB = DEF_COORD_BITS;
   // The back end works on one point at a time; three more can be queued.
   localparam int DRAIN_CYCLES = 1500;

   typedef struct {
      logic [SUM_W-1:0] total;
      logic             sat;
   } set_total_type;

   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic req_valid;
   logic req_stall;
   logic signed [CB-1:0] req_point_x;
   logic signed [CB-1:0] req_point_y;
   logic signed [CB-1:0] req_point_z;
   logic req_last_point;
   logic rsp_valid;
   logic rsp_stall;
   logic [SUM_W-1:0] rsp_residual_total;
   logic rsp_saturated;

   // Bench copy of the geometry and of the running sum.
   cfg_type geometry;
   logic [SUM_W-1:0] sum_acc;
   logic sum_clamped;
   set_total_type pending_totals[$];

   int error_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_asks;
   int hold_seen;
   int hold_left;

   cylinder_fit_residual_sum #(.COORD_BITS(CB)) DUT (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_point_z(req_point_z), .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_residual_total(rsp_residual_total), .rsp_saturated(rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(100_000_000);
      $display("[cylinder_fit_residual_sum] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Absolute radial residual of one point against the current geometry.
   function automatic logic [SUM_W-1:0] radial_residual(input logic signed [CB-1:0] px,
      input logic signed [CB-1:0] py, input logic signed [CB-1:0] pz);
      longint sx, sy, dx, dy, dz, c1, c2, c3;
      logic [127:0] num, den, quo;
      logic [63:0] root, cand;
      logic [63:0] dist_q8, rad;
      sx = longint'($signed(geometry.slope_x));
      sy = longint'($signed(geometry.slope_y));
      dx = longint'(px) * 256 - longint'($signed(geometry.origin_x));
      dy = longint'(py) * 256 - longint'($signed(geometry.origin_y));
      dz = longint'(pz) * 256;
      c1 = dy * 65536 - dz * sy;
      c2 = dz * sx - dx * 65536;
      c3 = dx * sy - dy * sx;
      if (c1 < 0) c1 = -c1;
      if (c2 < 0) c2 = -c2;
      if (c3 < 0) c3 = -c3;
      num = 128'(c1) * 128'(c1) + 128'(c2) * 128'(c2) + 128'(c3) * 128'(c3);
      den = 128'(sx * sx + sy * sy) + (128'd1 << 32);
      quo = num / den;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (128'(cand) * 128'(cand) <= quo) root = cand;
      end
      dist_q8 = root;
      rad = 64'(geometry.radius);
      return SUM_W'(dist_q8 >= rad ? dist_q8 - rad : rad - dist_q8);
   endfunction

   // Fold one accepted point into the bench sum; a last point closes the set.
   task automatic accumulate_point(input logic signed [CB-1:0] px,
      input logic signed [CB-1:0] py, input logic signed [CB-1:0] pz, input logic last);
      logic [SUM_W-1:0] diff;
      logic [SUM_W:0] wide_sum;
      set_total_type done;
      diff = radial_residual(px, py, pz);
      wide_sum = {1'b0, sum_acc} + {1'b0, diff};
      if (sum_clamped || wide_sum[SUM_W]) begin
         sum_acc = '1;
         sum_clamped = 1'b1;
      end else begin
         sum_acc = wide_sum[SUM_W-1:0];
      end
      if (last) begin
         done.total = sum_acc;
         done.sat = sum_clamped;
         pending_totals.push_back(done);
         sum_acc = '0;
         sum_clamped = 1'b0;
      end
   endtask

   // Send one point request, sometimes followed by a random gap.
   task automatic send_point(input logic signed [CB-1:0] px, input logic signed [CB-1:0] py,
      input logic signed [CB-1:0] pz, input logic last);
      int gap;
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      req_last_point <= last;
      do @(posedge clock); while (req_stall);
      accumulate_point(px, py, pz, last);
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every set total has arrived and the back end has drained.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_totals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write; only issued while the block is idle.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SLOPE_X:  geometry.slope_x = val[SLOPE_W-1:0];
         CSR_SLOPE_Y:  geometry.slope_y = val[SLOPE_W-1:0];
         CSR_ORIGIN_X: geometry.origin_x = val;
         CSR_ORIGIN_Y: geometry.origin_y = val;
         CSR_RADIUS:   geometry.radius = val;
         default: ;
      endcase
   endtask

   task automatic write_geometry(input logic [CSR_DATA_W-1:0] sx, input logic [CSR_DATA_W-1:0] sy,
      input logic [CSR_DATA_W-1:0] ox, input logic [CSR_DATA_W-1:0] oy,
      input logic [CSR_DATA_W-1:0] rad);
      wait_idle();
      write_reg(CSR_SLOPE_X, sx);
      write_reg(CSR_SLOPE_Y, sy);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_RADIUS, rad);
   endtask

   function automatic logic [CB-1:0] rand_coord();
      case ($urandom_range(3))
         0: return CB'($urandom_range(0, 65535));
         1: return CB'($signed($urandom_range(0, 200)) - 100);
         2: return $urandom_range(1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
         default: return CB'($urandom_range(0, 4095));
      endcase
   endfunction

   // Sets of random size with random points, each closed by a last point.
   task automatic stream_sets(input int point_total);
      int sent;
      int set_len;
      sent = 0;
      while (sent < point_total) begin
         set_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 12);
         for (int k = 0; k < set_len; k++)
            send_point(rand_coord(), rand_coord(), rand_coord(), k == set_len - 1);
         sent += set_len;
      end
   endtask

   // Extremes of the coordinates, a point on the axis and single-point sets.
   task automatic test_directed();
      write_geometry(24'd0, 24'd0, 24'd0, 24'd0, 24'd1280);
      send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_point(16'sd0, 16'sd0, 16'sd77, 1'b0);
      send_point(16'sd3, 16'sd4, 16'sd0, 1'b1);
      send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
      send_point(-16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
      send_point(16'sh7FFF, -16'sh8000, 16'sd0, 1'b1);
      send_point(-16'sd1, -16'sd1, -16'sd1, 1'b1);
      // Writes to unused register indexes must leave the geometry alone.
      wait_idle();
      write_reg(3'd5, 24'hFFFFFF);
      write_reg(3'd6, 24'h123456);
      write_reg(3'd7, 24'h800000);
      send_point(16'sd10, 16'sd20, 16'sd30, 1'b1);
      write_geometry(24'h07FFFF, 24'h080000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF);
      send_point(16'sh7FFF, -16'sh8000, 16'sh7FFF, 1'b0);
      send_point(-16'sh8000, 16'sh7FFF, -16'sh8000, 1'b0);
      send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
      // Axis through (2, -3, 0) with slope (1, 0.5): the first point lies on it.
      write_geometry(24'h010000, 24'h008000, 24'h000200, 24'hFFFD00, 24'd999);
      send_point(16'sd2, -16'sd3, 16'sd0, 1'b1);
      send_point(16'sd6, -16'sd1, 16'sd4, 1'b1);
   endtask

   task automatic test_geometry_sweep();
      write_geometry(24'hF80000, 24'h07FFFF, 24'h800000, 24'h7FFFFF, 24'd0);
      stream_sets(60);
      write_geometry(24'hFFFFFF, 24'h000001, 24'h000000, 24'hFFFFFF, 24'h000001);
      stream_sets(60);
   endtask

   // Receiver holds off for a long stretch while points keep coming.
   task automatic test_backpressure();
      wait_idle();
      hold_asks++;
      stream_sets(40);
      wait_idle();
   endtask

   task automatic test_random_phase(input int sp, input int rp, input int point_total);
      write_geometry(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
         CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      send_idle_pct = sp;
      recv_idle_pct = rp;
      stream_sets(point_total / 2);
      write_geometry(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
         CSR_DATA_W'($urandom), CSR_DATA_W'($urandom_range(0, 2560)));
      stream_sets(point_total / 2);
   endtask

   // Response side: random stall, long hold-offs, and the check of each total.
   always @(posedge clock) begin
      set_total_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_totals.size() == 0) begin
               report_mismatch("response with no set total pending");
            end else begin
               want = pending_totals.pop_front();
               if (rsp_residual_total !== want.total)
                  report_mismatch($sformatf("residual_total %0d, expected %0d",
                     rsp_residual_total, want.total));
               if (rsp_saturated !== want.sat)
                  report_mismatch($sformatf("saturated %0b, expected %0b",
                     rsp_saturated, want.sat));
            end
         end
         if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= 3000;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      int spin;
      error_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asks = 0;
      hold_seen = 0;
      hold_left = 0;
      geometry = '0;
      sum_acc = '0;
      sum_clamped = 1'b0;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      req_valid <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_point_z <= '0;
      req_last_point <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_geometry_sweep();
      test_backpressure();
      test_random_phase(11, 86, 560);
      test_random_phase(86, 11, 560);
      test_random_phase(0, 0, 560);

      req_valid <= 1'b0;
      spin = 0;
      while (pending_totals.size() != 0 && spin < 200000) begin
         @(posedge clock);
         spin++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_totals.size() != 0)
         report_mismatch($sformatf("%0d set totals never arrived", pending_totals.size()));
      if (error_count == 0)
         $display("[cylinder_fit_residual_sum] OK");
      else
         $display("[cylinder_fit_residual_sum] ERROR");
      $finish;
   end

endmodule
